### hw/rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

	// configuration register indexes
	localparam logic CFG_LINE_BYTES      = 1'b0;
	localparam logic CFG_BYTES_PER_PIXEL = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 14;
	localparam int LINE_BYTES_W = 14;
	localparam int PIXEL_BYTES_W = 4;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4,
		FILT_BAD   = 3'd5
	} filt_t;

	// one data byte as classified by the front
	typedef struct packed {
		logic [7:0] data;
		filt_t      filt;
		logic       first_line;
		logic       left_edge;
		logic       eol;
	} psu_item_t;

endpackage

### hw/rtl/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front
// Scanline tracking: takes filter bytes, tags each data byte with its filter,
// position and edge flags, and pushes it to the queue.
// ----------------------------------------------------------------------------
module psu_front #(
	parameter int MAX_LINE_BYTES  = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [psu_pkg::LINE_BYTES_W-1:0]     line_bytes,
	input  logic [psu_pkg::PIXEL_BYTES_W-1:0]    bytes_per_pixel,
	input  logic                                 accept,
	input  logic [7:0]                           filtered_byte,
	input  logic                                 start_of_image,
	output logic                                 push,
	output psu_pkg::psu_item_t                   push_item,
	output logic [$clog2(MAX_LINE_BYTES)-1:0]    push_pos,
	output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] push_bpp_idx
);

	localparam int AW = $clog2(MAX_LINE_BYTES);
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int LW = $clog2(MAX_LINE_BYTES + 1);
	localparam int CW = (LW > psu_pkg::LINE_BYTES_W) ? LW : psu_pkg::LINE_BYTES_W;

	function automatic psu_pkg::filt_t classify(input logic [7:0] code);
		psu_pkg::filt_t f;
		unique case (code)
			8'd0:    f = psu_pkg::FILT_NONE;
			8'd1:    f = psu_pkg::FILT_SUB;
			8'd2:    f = psu_pkg::FILT_UP;
			8'd3:    f = psu_pkg::FILT_AVG;
			8'd4:    f = psu_pkg::FILT_PAETH;
			default: f = psu_pkg::FILT_BAD;
		endcase
		return f;
	endfunction

	logic           awaiting_q;
	logic           first_line_q;
	logic [AW-1:0]  pos_q;
	psu_pkg::filt_t filt_q;

	logic [CW-1:0]  len_eff;
	logic [3:0]     bpp_eff;
	logic           eol;

	always_comb begin
		if (line_bytes == '0) begin
			len_eff = CW'(1);
		end else if (CW'(line_bytes) > CW'(MAX_LINE_BYTES)) begin
			len_eff = CW'(MAX_LINE_BYTES);
		end else begin
			len_eff = CW'(line_bytes);
		end
		if (bytes_per_pixel == '0) begin
			bpp_eff = 4'd1;
		end else if (bytes_per_pixel > 4'(MAX_PIXEL_BYTES)) begin
			bpp_eff = 4'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bytes_per_pixel;
		end
	end

	assign eol  = (CW'(pos_q) + CW'(1)) >= len_eff;
	assign push = accept && !start_of_image && !awaiting_q;

	always_comb begin
		push_item.data       = filtered_byte;
		push_item.filt       = filt_q;
		push_item.first_line = first_line_q;
		push_item.left_edge  = pos_q < AW'(bpp_eff);
		push_item.eol        = eol;
	end
	assign push_pos     = pos_q;
	assign push_bpp_idx = PW'(bpp_eff - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b1;
			first_line_q <= 1'b1;
			pos_q        <= '0;
			filt_q       <= psu_pkg::FILT_NONE;
		end else if (accept) begin
			if (start_of_image || awaiting_q) begin
				filt_q     <= classify(filtered_byte);
				awaiting_q <= 1'b0;
				pos_q      <= '0;
				if (start_of_image) begin
					first_line_q <= 1'b1;
				end
			end else if (eol) begin
				pos_q        <= '0;
				awaiting_q   <= 1'b1;
				first_line_q <= 1'b0;
			end else begin
				pos_q <= pos_q + AW'(1);
			end
		end
	end

	// a line's last byte is always followed by a filter byte
	a_eol_wait_filter: assert property (@(posedge clk) disable iff (!arst_n)
		push && eol |=> awaiting_q && pos_q == '0)
		else $error("front: line end did not rearm filter byte");

	// data bytes never arrive while a filter byte is due
	a_no_push_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !awaiting_q)
		else $error("front: data byte pushed while awaiting filter byte");

endmodule

### hw/rtl/psu_queue.sv
// ----------------------------------------------------------------------------
// psu_queue
// Small register FIFO between the scanline tracker and the reconstruction.
// ----------------------------------------------------------------------------
module psu_queue #(
	parameter int W     = 32,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         not_empty,
	output logic         full
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [IW-1:0] rd_ptr_q;
	logic [IW-1:0] wr_ptr_q;
	logic [NW-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == NW'(DEPTH);

	function automatic logic [IW-1:0] next_ptr(input logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("queue: pop while empty");

endmodule

### hw/rtl/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back
// Reconstruction: line store read, predictor (Sub/Up/Average/Paeth), history
// shift registers and the output register.
// ----------------------------------------------------------------------------
module psu_back #(
	parameter int MAX_LINE_BYTES  = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  psu_pkg::psu_item_t                   q_item,
	input  logic [$clog2(MAX_LINE_BYTES)-1:0]    q_pos,
	input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] q_bpp_idx,
	output logic                                 q_pop,
	output logic                                 pix_valid,
	input  logic                                 pix_stall,
	output logic [7:0]                           pixel_byte,
	output logic                                 end_of_line,
	output logic                                 bad_filter
);

	localparam int AW = $clog2(MAX_LINE_BYTES);
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [7:0] line_mem [MAX_LINE_BYTES];
	logic [7:0] left_hist_q  [MAX_PIXEL_BYTES];
	logic [7:0] above_hist_q [MAX_PIXEL_BYTES];

	logic               s1_valid_q;
	psu_pkg::psu_item_t item_s1;
	logic [AW-1:0]      pos_s1;
	logic [PW-1:0]      bpp_idx_s1;
	logic [7:0]         rd_data_s1;
	logic               byp_s1;
	logic [7:0]         byp_data_s1;

	logic               out_valid_q;
	logic [7:0]         pixel_q;
	logic               eol_q;
	logic               bad_q;

	logic               advance;
	logic               s1_fire;
	logic [7:0]         a, b, c, pred, r;
	logic [9:0]         da, db, dc, pa, pb, pc;

	assign advance = !s1_valid_q || !out_valid_q || !pix_stall;
	assign s1_fire = s1_valid_q && advance;
	assign q_pop   = q_valid && advance;

	always_comb begin
		if (item_s1.first_line) begin
			b = 8'd0;
		end else if (byp_s1) begin
			b = byp_data_s1;
		end else begin
			b = rd_data_s1;
		end
		a = item_s1.left_edge ? 8'd0 : left_hist_q[bpp_idx_s1];
		c = (item_s1.left_edge || item_s1.first_line) ? 8'd0 : above_hist_q[bpp_idx_s1];

		// pa = |p-a| = |b-c|, pb = |a-c|, pc = |a+b-2c|
		da = {2'b00, b} - {2'b00, c};
		db = {2'b00, a} - {2'b00, c};
		dc = da + db;
		pa = da[9] ? 10'(-da) : da;
		pb = db[9] ? 10'(-db) : db;
		pc = dc[9] ? 10'(-dc) : dc;

		case (item_s1.filt)
			psu_pkg::FILT_SUB: pred = a;
			psu_pkg::FILT_UP:  pred = b;
			psu_pkg::FILT_AVG: pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
			psu_pkg::FILT_PAETH: begin
				if (pa <= pb && pa <= pc) begin
					pred = a;
				end else if (pb <= pc) begin
					pred = b;
				end else begin
					pred = c;
				end
			end
			default: pred = 8'd0;
		endcase
		r = item_s1.data + pred;
	end

	// line store: one write from stage 1, one registered read for the next item
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			line_mem[pos_s1] <= r;
		end
		if (q_pop) begin
			rd_data_s1 <= line_mem[q_pos];
		end
	end

	// forward a result written in the same cycle as the read of its address
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1     <= q_item;
			pos_s1      <= q_pos;
			bpp_idx_s1  <= q_bpp_idx;
			byp_s1      <= s1_fire && (pos_s1 == q_pos);
			byp_data_s1 <= r;
		end
		if (s1_fire) begin
			pixel_q <= r;
			eol_q   <= item_s1.eol;
			bad_q   <= item_s1.filt == psu_pkg::FILT_BAD;
			left_hist_q[0]  <= r;
			above_hist_q[0] <= b;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_hist_q[i]  <= left_hist_q[i-1];
				above_hist_q[i] <= above_hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				s1_valid_q <= q_valid;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid   = out_valid_q;
	assign pixel_byte  = pixel_q;
	assign end_of_line = eol_q;
	assign bad_filter  = bad_q;

	// a new result only appears after stage 1 held an item
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("back: result without stage 1 item");

endmodule

### hw/rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (None/Sub/Up/Average/Paeth) on a byte stream.
// ----------------------------------------------------------------------------
// Takes one filtered byte per cycle while filt_stall is low. The first byte of
// each scanline (and any byte flagged start_of_image) selects the filter and
// gives no result; every following byte gives one reconstructed byte. The
// block raises filt_stall while its queue is full, as when pix_stall holds the
// output. A front stage tracks line position and filter, a four-entry queue
// decouples it from the back end, and the back end reads the previous line
// from a single-port-write, registered-read line store of MAX_LINE_BYTES
// bytes, forwarding a result written in the same cycle as its read. A data
// byte passes through the queue, the stage-1 register and the output register
// before pix_valid rises. The line store is not cleared after reset; its
// contents are not used before the first line of an image has filled it.
// Write line_bytes and bytes_per_pixel only while no results are outstanding;
// a line length of 0 acts as 1 and values above the maximum saturate.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_LINE_BYTES  = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [psu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                filt_valid,
	output logic                                filt_stall,
	input  logic [7:0]                          filtered_byte,
	input  logic                                start_of_image,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output logic [7:0]                          pixel_byte,
	output logic                                end_of_line,
	output logic                                bad_filter
);

	localparam int AW = $clog2(MAX_LINE_BYTES);
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int IW = $bits(psu_pkg::psu_item_t);
	localparam int DW = IW + AW + PW;

	logic [psu_pkg::LINE_BYTES_W-1:0]  line_bytes_q;
	logic [psu_pkg::PIXEL_BYTES_W-1:0] bpp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= psu_pkg::LINE_BYTES_W'(1);
			bpp_q        <= psu_pkg::PIXEL_BYTES_W'(1);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				psu_pkg::CFG_LINE_BYTES:
					line_bytes_q <= cfg_data[psu_pkg::LINE_BYTES_W-1:0];
				psu_pkg::CFG_BYTES_PER_PIXEL:
					bpp_q <= cfg_data[psu_pkg::PIXEL_BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	logic               accept;
	logic               push;
	psu_pkg::psu_item_t push_item;
	logic [AW-1:0]      push_pos;
	logic [PW-1:0]      push_bpp_idx;
	logic               q_full;
	logic               q_not_empty;
	logic               q_pop;
	logic [DW-1:0]      q_head;
	psu_pkg::psu_item_t head_item;
	logic [AW-1:0]      head_pos;
	logic [PW-1:0]      head_bpp_idx;

	assign filt_stall = q_full;
	assign accept     = filt_valid && !filt_stall;

	psu_front #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.line_bytes     (line_bytes_q),
		.bytes_per_pixel(bpp_q),
		.accept         (accept),
		.filtered_byte  (filtered_byte),
		.start_of_image (start_of_image),
		.push           (push),
		.push_item      (push_item),
		.push_pos       (push_pos),
		.push_bpp_idx   (push_bpp_idx)
	);

	psu_queue #(
		.W    (DW),
		.DEPTH(psu_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_item, push_pos, push_bpp_idx}),
		.pop      (q_pop),
		.head     (q_head),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	assign {head_item, head_pos, head_bpp_idx} = q_head;

	psu_back #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_item     (head_item),
		.q_pos      (head_pos),
		.q_bpp_idx  (head_bpp_idx),
		.q_pop      (q_pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel_byte (pixel_byte),
		.end_of_line(end_of_line),
		.bad_filter (bad_filter)
	);

endmodule
